/* rtl/median_3x3_rgb_filter_top_defines.svh */
// Assertion macros for the median filter checker.
`ifndef MEDIAN_3X3_RGB_FILTER_TOP_DEFINES_SVH
`define MEDIAN_3X3_RGB_FILTER_TOP_DEFINES_SVH
// implication checked on every clock unless in reset
`define MF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define MF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/mf3_pkg.sv */
// Package: constants of the 3x3 median filter.
package mf3_pkg;
    localparam int MAX_WIDTH_DEF    = 4096;
    localparam int CHANNEL_BITS_DEF = 16;
    localparam int CFG_IDX_BITS     = 1;
    localparam int CFG_DATA_BITS    = 16;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;
    localparam int COL_BITS   = 12;
    localparam int ROW_BITS   = 16;
    localparam int NUM_TAPS   = 9;
    localparam int MAX_RESULTS = 4;
endpackage

/* rtl/mf3_stream_if.sv */
// Valid/ready stream interface carrying one payload word.
interface mf3_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/median_3x3_rgb_filter_top.sv */
// Top level of the streaming 3x3 RGB median filter.
// Pixels arrive on the input channel in raster order, one word per pixel
// (red, green, blue). Results leave on the output channel tagged with their
// column and row; run_last marks the last word caused by one pixel and
// frame_done the bottom-right pixel of the frame.
// Throughput: one pixel per cycle while the receiver takes every word; at a row
// end a pixel causes two words, at the last row up to four, and the input stalls
// while stage 2 passes them one by one to the single output register.
// An accepted pixel passes the line memory read, the window update and the
// median network into the output register.
// Two line memories of 2*MAX_WIDTH words hold the previous rows; a same
// column read right after a write is forwarded.
// Reset clears the counters, sets width and height to 4096 and empties the
// pipeline; the line memories are not cleared and need no clearing pass.
// When the receiver stalls, the output word holds and the pipeline backs up
// to the input. Writing a register restarts the frame at (0,0).
module median_3x3_rgb_filter_top #(
    parameter int MAX_WIDTH    = mf3_pkg::MAX_WIDTH_DEF,
    parameter int CHANNEL_BITS = mf3_pkg::CHANNEL_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [mf3_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [mf3_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic [CHANNEL_BITS-1:0] i_in_red,
    input  logic [CHANNEL_BITS-1:0] i_in_green,
    input  logic [CHANNEL_BITS-1:0] i_in_blue,
    output logic o_out_valid,
    input  logic i_out_ready,
    output logic [11:0] o_out_col,
    output logic [15:0] o_out_row,
    output logic [CHANNEL_BITS-1:0] o_med_red,
    output logic [CHANNEL_BITS-1:0] o_med_green,
    output logic [CHANNEL_BITS-1:0] o_med_blue,
    output logic o_run_last,
    output logic o_frame_done
);
    logic [3*CHANNEL_BITS-1:0] med;
    mf3_core #(.MAX_WIDTH(MAX_WIDTH), .CHANNEL_BITS(CHANNEL_BITS)) u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_px({i_in_blue, i_in_green, i_in_red}),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_col(o_out_col), .o_row(o_out_row), .o_med(med),
        .o_run_last(o_run_last), .o_frame_done(o_frame_done));
    assign o_med_red   = med[CHANNEL_BITS-1:0];
    assign o_med_green = med[2*CHANNEL_BITS-1:CHANNEL_BITS];
    assign o_med_blue  = med[3*CHANNEL_BITS-1:2*CHANNEL_BITS];
endmodule

/* rtl/mf3_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module mf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

/* rtl/mf3_core.sv */
// Window, median network and result sequencing of the filter.
module mf3_core #(
    parameter int MAX_WIDTH    = mf3_pkg::MAX_WIDTH_DEF,
    parameter int CHANNEL_BITS = mf3_pkg::CHANNEL_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [mf3_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [mf3_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [3*CHANNEL_BITS-1:0] i_px,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [11:0]             o_col,
    output logic [15:0]             o_row,
    output logic [3*CHANNEL_BITS-1:0] o_med,
    output logic                    o_run_last,
    output logic                    o_frame_done
);
    localparam int PW = 3 * CHANNEL_BITS;
    localparam int XB = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int AB = $clog2(2 * MAX_WIDTH);
    localparam int WB = $clog2(MAX_WIDTH + 1);
    typedef logic [CHANNEL_BITS-1:0] t_ch;

    function automatic void cmpx(input t_ch a, input t_ch b, output t_ch lo, output t_ch hi);
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
    endfunction

    // 3-sorter
    function automatic void sort3(input t_ch a, input t_ch b, input t_ch c,
                                  output t_ch l, output t_ch m, output t_ch h);
        t_ch x0, x1, y0, y1;
        cmpx(a, b, x0, x1);
        cmpx(x1, c, y0, h);
        cmpx(x0, y0, l, m);
    endfunction

    function automatic t_ch med3(input t_ch a, input t_ch b, input t_ch c);
        t_ch l, m, h;
        sort3(a, b, c, l, m, h);
        return m;
    endfunction

    // config
    logic [12:0] r_fw;
    logic [15:0] r_fh;
    logic [XB-1:0] r_x;
    logic [15:0] r_y;
    logic [WB-1:0] w_eff;
    logic [15:0]   h_eff;
    always_comb begin
        if (r_fw == 13'd0) w_eff = WB'(1);
        else if (32'(r_fw) > MAX_WIDTH) w_eff = WB'(MAX_WIDTH);
        else w_eff = WB'(r_fw);
        h_eff = (r_fh == 16'd0) ? 16'd1 : r_fh;
    end

    // stage 0: accept, issue line reads
    logic acc;
    logic [XB-1:0] xc;
    logic [15:0]   yc;
    always_comb begin
        xc = (32'(r_x) >= 32'(w_eff)) ? XB'(w_eff - WB'(1)) : r_x;
        yc = (r_y >= h_eff) ? h_eff - 16'd1 : r_y;
    end

    // stage 1 regs
    logic          r1_v;
    logic [XB-1:0] r1_x;
    logic [15:0]   r1_y;
    logic [PW-1:0] r1_px;
    logic          r1_xl, r1_yl;

    logic [PW-1:0] top_rd, mid_rd, top_v, mid_v;
    // forward from stage 1 write when same column is read next cycle (width 1)
    logic          r_fwd;
    logic [PW-1:0] r_fwd_top, r_fwd_mid;

    always_comb begin
        if (r1_y == 16'd0) begin
            top_v = r1_px;
            mid_v = r1_px;
        end else if (r_fwd) begin
            top_v = r_fwd_top;
            mid_v = r_fwd_mid;
        end else begin
            top_v = top_rd;
            mid_v = mid_rd;
        end
    end

    // window (3 rows x 3 cols)
    logic [PW-1:0] r_win [9];
    // stage 2: result expansion
    logic          r2_v;
    logic [XB-1:0] r2_x;
    logic [15:0]   r2_y;
    logic          r2_xl;
    logic [1:0]    r2_k;
    logic [1:0]    r2_n;
    logic          r2_has_c0, r2_has_r0;

    // stage 3 output register
    logic          r_ov;
    logic [11:0]   r_ocol;
    logic [15:0]   r_orow;
    logic [PW-1:0] r_omed;
    logic          r_olast, r_odone;

    logic out_free;
    assign out_free = !r_ov || i_out_ready;

    logic r2_busy;
    logic r2_pop;
    assign r2_pop = r2_v && out_free && (r2_k == r2_n);
    assign r2_busy = r2_v && !r2_pop;
    // stage 1 can move into stage 2 only when stage 2 frees
    logic s1_go;
    assign s1_go = !r2_busy;
    assign o_in_ready = s1_go;
    assign acc = i_in_valid && o_in_ready;

    // line write when stage 1 leaves; held word re-reads its own column
    logic          ram_we;
    logic [XB-1:0] ram_raddr;
    assign ram_we    = r1_v && s1_go;
    assign ram_raddr = s1_go ? xc : r1_x;

    mf3_ram #(.WIDTH(PW), .DEPTH(2 * MAX_WIDTH)) u_ram_top (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(AB'(r1_x)), .i_wdata(mid_v),
        .i_raddr(AB'(ram_raddr)), .o_rdata(top_rd));
    mf3_ram #(.WIDTH(PW), .DEPTH(2 * MAX_WIDTH)) u_ram_mid (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(AB'(r1_x)), .i_wdata(r1_px),
        .i_raddr(AB'(ram_raddr)), .o_rdata(mid_rd));

    // counts of results for stage-1 item
    logic          c_r0, c_r1, c_c0, c_c1;
    always_comb begin
        c_r0 = (r1_y != 16'd0);
        c_r1 = r1_yl;
        c_c0 = (r1_x != '0);
        c_c1 = r1_xl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= 13'd4096;
            r_fh <= 16'd4096;
            r_x  <= '0;
            r_y  <= '0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r_ov <= 1'b0;
            r_fwd <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    mf3_pkg::REG_FRAME_WIDTH: begin
                        r_fw <= i_cfg_data[12:0];
                    end
                    mf3_pkg::REG_FRAME_HEIGHT: begin
                        r_fh <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
                r_x <= '0;
                r_y <= '0;
            end else if (acc) begin
                if (32'(xc) + 1 >= 32'(w_eff)) begin
                    r_x <= '0;
                    r_y <= (32'(yc) + 1 >= 32'(h_eff)) ? 16'd0 : yc + 16'd1;
                end else begin
                    r_x <= xc + XB'(1);
                    r_y <= yc;
                end
            end
            if (s1_go) begin
                r1_v <= acc;
                r_fwd <= acc && r1_v && (xc == r1_x);
            end
            if (s1_go) begin
                r2_v <= r1_v && ((c_r0 || c_r1) && (c_c0 || c_c1));
            end
            if (r2_v && out_free) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (s1_go && r1_v) begin
                r2_k <= 2'd0;
            end else if (r2_v && out_free) begin
                r2_k <= r2_k + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && acc) begin
            r1_x  <= xc;
            r1_y  <= yc;
            r1_px <= i_px;
            r1_xl <= (32'(xc) == 32'(w_eff) - 1);
            r1_yl <= (yc == h_eff - 16'd1);
        end
        if (s1_go) begin
            r_fwd_top <= mid_v;
            r_fwd_mid <= r1_px;
        end
        if (s1_go && r1_v) begin
            for (int r = 0; r < 3; r++) begin
                logic [PW-1:0] nv;
                nv = (r == 0) ? top_v : (r == 1) ? mid_v : r1_px;
                if (r1_x == '0) begin
                    r_win[r*3]   <= nv;
                    r_win[r*3+1] <= nv;
                end else begin
                    r_win[r*3]   <= r_win[r*3+1];
                    r_win[r*3+1] <= r_win[r*3+2];
                end
                r_win[r*3+2] <= nv;
            end
            r2_x <= r1_x;
            r2_y <= r1_y;
            r2_xl <= c_c1;
            r2_has_c0 <= c_c0;
            r2_has_r0 <= c_r0;
            r2_n <= 2'(({1'b0, c_r0} + {1'b0, c_r1}) * ({1'b0, c_c0} + {1'b0, c_c1}) - 1);
        end
    end

    // pick result k of stage 2
    logic ncol2;
    logic use_r0, use_c0, last_k;
    logic [11:0] ox;
    logic [15:0] oy;
    logic [PW-1:0] med;
    always_comb begin
        ncol2 = r2_has_c0 && r2_xl;
        if (ncol2) begin
            use_r0 = r2_has_r0 && (r2_k[1] == 1'b0);
            use_c0 = (r2_k[0] == 1'b0);
        end else begin
            use_r0 = r2_has_r0 && (r2_k == 2'd0);
            use_c0 = r2_has_c0;
        end
        ox = use_c0 ? 12'(r2_x - XB'(1)) : 12'(r2_x);
        oy = use_r0 ? r2_y - 16'd1 : r2_y;
        last_k = (r2_k == r2_n);
        for (int ch = 0; ch < 3; ch++) begin
            t_ch v [9];
            t_ch l0, m0, h0, l1, m1, h1, l2, m2, h2;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    int rr, cc;
                    rr = use_r0 ? i : ((i == 0) ? 1 : 2);
                    cc = use_c0 ? j : ((j == 0) ? 1 : 2);
                    v[i*3+j] = r_win[rr*3+cc][ch*CHANNEL_BITS +: CHANNEL_BITS];
                end
            end
            sort3(v[0], v[1], v[2], l0, m0, h0);
            sort3(v[3], v[4], v[5], l1, m1, h1);
            sort3(v[6], v[7], v[8], l2, m2, h2);
            med[ch*CHANNEL_BITS +: CHANNEL_BITS] = med3(
                (l0 > l1) ? ((l0 > l2) ? l0 : l2) : ((l1 > l2) ? l1 : l2),
                med3(m0, m1, m2),
                (h0 < h1) ? ((h0 < h2) ? h0 : h2) : ((h1 < h2) ? h1 : h2));
        end
    end

    always_ff @(posedge i_clk) begin
        if (r2_v && out_free) begin
            r_ocol  <= ox;
            r_orow  <= oy;
            r_omed  <= med;
            r_olast <= last_k;
            r_odone <= (32'(ox) == 32'(w_eff) - 1) && (oy == h_eff - 16'd1);
        end
    end

    assign o_out_valid  = r_ov;
    assign o_col        = r_ocol;
    assign o_row        = r_orow;
    assign o_med        = r_omed;
    assign o_run_last   = r_olast;
    assign o_frame_done = r_odone;
endmodule

/* rtl/mf3_checker.sv */
// Port-level assertions of the median filter, bound to the top level.
`include "median_3x3_rgb_filter_top_defines.svh"
module mf3_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_run_last,
    input logic o_frame_done
);
    `MF_ASSERT_IMP(a_done_last, i_clk, i_rst_n, o_out_valid && o_frame_done, o_run_last)
    `MF_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `MF_ASSERT_IMP(a_stall_back, i_clk, i_rst_n, o_out_valid && !i_out_ready && !o_run_last,
        !o_in_ready)
endmodule

bind median_3x3_rgb_filter_top mf3_checker u_mf3_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_in_ready(o_in_ready),
    .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
    .o_run_last(o_run_last), .o_frame_done(o_frame_done));

/* tb/median_3x3_rgb_filter_top_tb.sv */
// Self-checking testbench for the streaming 3x3 RGB median filter.
module median_3x3_rgb_filter_top_tb;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_pix;

    typedef struct packed {
        logic [11:0] col;
        logic [15:0] row;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        run_last;
        logic        frame_done;
    } t_med;

    typedef logic [2:0][15:0] t_rgb;

    typedef struct {
        t_pix pix;
        bit   typed;
    } t_stim_row;

    localparam int LINE_LEN     = mf3_pkg::MAX_WIDTH_DEF;
    localparam int SETTLE_CYC   = 12;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int HOLD_CYC     = 300;
    localparam int HOLD_AT_WORD = 50;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [mf3_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [mf3_pkg::CFG_DATA_BITS-1:0] i_cfg_data;

    mf3_stream_if #(.T(t_pix)) pix_if ();
    mf3_stream_if #(.T(t_med)) med_if ();

    median_3x3_rgb_filter_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (pix_if.valid),
        .o_in_ready   (pix_if.ready),
        .i_in_red     (pix_if.data.red),
        .i_in_green   (pix_if.data.green),
        .i_in_blue    (pix_if.data.blue),
        .o_out_valid  (med_if.valid),
        .i_out_ready  (med_if.ready),
        .o_out_col    (med_if.data.col),
        .o_out_row    (med_if.data.row),
        .o_med_red    (med_if.data.red),
        .o_med_green  (med_if.data.green),
        .o_med_blue   (med_if.data.blue),
        .o_run_last   (med_if.data.run_last),
        .o_frame_done (med_if.data.frame_done)
    );

    // predictor state
    logic [12:0] frame_w;
    logic [15:0] frame_h;
    t_rgb        line_mem [2*LINE_LEN];
    t_rgb        wnd [9];
    int unsigned col_pos;
    int unsigned row_pos;

    t_med        exp_words [$];
    int          err_count = 0;
    int          words_seen = 0;
    longint      cycles = 0;
    bit          src_fast;
    bit          snk_fast;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        err_count++;
    endtask

    function automatic t_rgb to_rgb(input t_pix p);
        t_rgb v;
        v[0] = p.red;
        v[1] = p.green;
        v[2] = p.blue;
        return v;
    endfunction

    function automatic logic [15:0] median9(input logic [15:0] v [9]);
        logic [15:0] s [9];
        logic [15:0] t;
        int j;
        for (int i = 0; i < 9; i++) begin
            t = v[i];
            j = i;
            while (j > 0 && s[j-1] > t) begin
                s[j] = s[j-1];
                j--;
            end
            s[j] = t;
        end
        return s[4];
    endfunction

    function automatic int tap(input bit edge_sel, input int k);
        if (!edge_sel)
            return k;
        return (k == 0) ? 1 : 2;
    endfunction

    function automatic t_med filter_word(input int unsigned ox, input int unsigned oy,
                                         input bit row_edge, input bit col_edge,
                                         input bit done);
        t_med m;
        logic [15:0] v [9];
        logic [15:0] md [3];
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    v[i*3+j] = wnd[tap(row_edge, i)*3 + tap(col_edge, j)][ch];
            md[ch] = median9(v);
        end
        m.col        = ox[11:0];
        m.row        = oy[15:0];
        m.red        = md[0];
        m.green      = md[1];
        m.blue       = md[2];
        m.run_last   = 1'b0;
        m.frame_done = done;
        return m;
    endfunction

    // Works out the words one accepted pixel causes and advances the position.
    task automatic filter_pixel(input t_pix p, output t_med words [$]);
        int unsigned w, h, x, y;
        t_rgb px, top, mid, nv;
        int unsigned oys [$];
        int unsigned oxs [$];
        bit rse [$];
        bit cse [$];
        words = {};
        w = frame_w;
        h = frame_h;
        if (w < 1) w = 1;
        if (w > LINE_LEN) w = LINE_LEN;
        if (h < 1) h = 1;
        x = (col_pos >= w) ? w - 1 : col_pos;
        y = (row_pos >= h) ? h - 1 : row_pos;
        px = to_rgb(p);
        if (y == 0) begin
            top = px;
            mid = px;
        end else begin
            top = line_mem[x];
            mid = line_mem[LINE_LEN + x];
        end
        line_mem[x] = mid;
        line_mem[LINE_LEN + x] = px;
        for (int r = 0; r < 3; r++) begin
            nv = (r == 0) ? top : (r == 1) ? mid : px;
            if (x == 0) begin
                wnd[r*3] = nv;
                wnd[r*3+1] = nv;
            end else begin
                wnd[r*3] = wnd[r*3+1];
                wnd[r*3+1] = wnd[r*3+2];
            end
            wnd[r*3+2] = nv;
        end
        if (y >= 1) begin oys.push_back(y - 1); rse.push_back(1'b0); end
        if (y == h - 1) begin oys.push_back(y); rse.push_back(1'b1); end
        if (x >= 1) begin oxs.push_back(x - 1); cse.push_back(1'b0); end
        if (x == w - 1) begin oxs.push_back(x); cse.push_back(1'b1); end
        foreach (oys[r])
            foreach (oxs[c])
                words.push_back(filter_word(oxs[c], oys[r], rse[r], cse[c],
                                            oxs[c] == w - 1 && oys[r] == h - 1));
        if (words.size() > 0)
            words[words.size()-1].run_last = 1'b1;
        if (x + 1 >= w) begin
            col_pos = 0;
            row_pos = (y + 1 >= h) ? 0 : y + 1;
        end else begin
            col_pos = x + 1;
            row_pos = y;
        end
    endtask

    task automatic send_pixel(input t_pix p, input bit typed);
        int gap;
        t_med words [$];
        t_med want;
        gap = src_fast ? 0 : $urandom_range(0, 6);
        repeat (gap) begin
            @(negedge i_clk);
            pix_if.valid = 1'b0;
        end
        @(negedge i_clk);
        pix_if.valid = 1'b1;
        pix_if.data  = p;
        do @(posedge i_clk); while (!pix_if.ready);
        filter_pixel(p, words);
        if (typed) begin
            // 1x1 frame: all nine taps are the pixel itself
            want = '{col: 12'd0, row: 16'd0, red: p.red, green: p.green,
                     blue: p.blue, run_last: 1'b1, frame_done: 1'b1};
            exp_words.push_back(want);
        end else begin
            foreach (words[i])
                exp_words.push_back(words[i]);
        end
        if ($urandom_range(0, 19) == 0)
            src_fast = ~src_fast;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        pix_if.valid = 1'b0;
        while (exp_words.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mf3_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [mf3_pkg::CFG_DATA_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == mf3_pkg::REG_FRAME_WIDTH)
            frame_w = val[12:0];
        else
            frame_h = val;
        col_pos = 0;
        row_pos = 0;
    endtask

    function automatic t_pix rand_pix(input int mode);
        t_pix p;
        case (mode)
            0: begin
                p.red   = 16'($urandom_range(0, 3));
                p.green = 16'($urandom_range(0, 3));
                p.blue  = 16'($urandom_range(0, 3));
            end
            1: begin
                p.red   = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                p.green = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                p.blue  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
            default: begin
                p.red   = 16'($urandom);
                p.green = 16'($urandom);
                p.blue  = 16'($urandom);
            end
        endcase
        if (mode > 1)
            p.red = 16'($urandom);
        return p;
    endfunction

    task automatic run_frame(input int unsigned w, input int unsigned h,
                             input int unsigned count);
        write_reg(mf3_pkg::REG_FRAME_WIDTH, w[15:0]);
        write_reg(mf3_pkg::REG_FRAME_HEIGHT, h[15:0]);
        for (int unsigned i = 0; i < count; i++)
            send_pixel(rand_pix($urandom_range(0, 4)), 1'b0);
        wait_idle();
    endtask

    // output side: random stalls, one long hold-off, word checking
    initial begin
        int stall;
        t_med got, want;
        med_if.ready = 1'b0;
        snk_fast = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = snk_fast ? 0 : $urandom_range(0, 6);
            if (words_seen == HOLD_AT_WORD)
                stall = HOLD_CYC;
            repeat (stall) begin
                @(negedge i_clk);
                med_if.ready = 1'b0;
            end
            @(negedge i_clk);
            med_if.ready = 1'b1;
            do @(posedge i_clk); while (!med_if.valid);
            got = med_if.data;
            words_seen++;
            if ($urandom_range(0, 19) == 0)
                snk_fast = ~snk_fast;
            if (exp_words.size() == 0) begin
                report($sformatf("unexpected word col %0d row %0d", got.col, got.row));
            end else begin
                want = exp_words.pop_front();
                if (got.col !== want.col)
                    report($sformatf("col %0d, want %0d", got.col, want.col));
                if (got.row !== want.row)
                    report($sformatf("row %0d, want %0d", got.row, want.row));
                if (got.red !== want.red)
                    report($sformatf("red %h, want %h at (%0d,%0d)",
                                     got.red, want.red, want.col, want.row));
                if (got.green !== want.green)
                    report($sformatf("green %h, want %h at (%0d,%0d)",
                                     got.green, want.green, want.col, want.row));
                if (got.blue !== want.blue)
                    report($sformatf("blue %h, want %h at (%0d,%0d)",
                                     got.blue, want.blue, want.col, want.row));
                if (got.run_last !== want.run_last)
                    report($sformatf("run_last %b at (%0d,%0d)",
                                     got.run_last, want.col, want.row));
                if (got.frame_done !== want.frame_done)
                    report($sformatf("frame_done %b at (%0d,%0d)",
                                     got.frame_done, want.col, want.row));
            end
        end
    end

    initial begin
        t_stim_row   corners [] = '{
            '{'{16'h0000, 16'h0000, 16'h0000}, 1'b1},
            '{'{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1},
            '{'{16'hFFFF, 16'h0000, 16'hFFFF}, 1'b1},
            '{'{16'h0000, 16'hFFFF, 16'h0000}, 1'b1},
            '{'{16'hAAAA, 16'h5555, 16'hAAAA}, 1'b1},
            '{'{16'h5555, 16'hAAAA, 16'h5555}, 1'b1},
            '{'{16'h8000, 16'h0001, 16'h7FFF}, 1'b1},
            '{'{16'h0001, 16'h8000, 16'hFFFE}, 1'b1}
        };
        int unsigned rand_items;
        int unsigned w, h, n;

        src_fast     = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = mf3_pkg::REG_FRAME_WIDTH;
        i_cfg_data   = '0;
        pix_if.valid = 1'b0;
        pix_if.data  = '0;
        frame_w      = 13'd4096;
        frame_h      = 16'd4096;
        col_pos      = 0;
        row_pos      = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset size: a few pixels of the first row, no words
        for (int i = 0; i < 5; i++)
            send_pixel(rand_pix(2), 1'b0);
        wait_idle();

        write_reg(mf3_pkg::REG_FRAME_WIDTH, 16'd1);
        write_reg(mf3_pkg::REG_FRAME_HEIGHT, 16'd1);
        foreach (corners[i])
            send_pixel(corners[i].pix, corners[i].typed);
        wait_idle();

        run_frame(0, 0, 3);           // zero sizes act as 1
        run_frame(16'hFFFF, 1, 20);   // width above the maximum
        run_frame(8191, 2, 20);       // partial, then restart by register write
        run_frame(3, 65535, 12);
        run_frame(1, 4, 8);
        run_frame(2, 2, 8);
        run_frame(4096, 3, 10);

        rand_items = 0;
        while (rand_items < 70) begin
            w = $urandom_range(1, 10);
            h = $urandom_range(1, 6);
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, w * h) : w * h;
            if ($urandom_range(0, 3) == 0)
                n = n + w * h;
            run_frame(w, h, n);
            rand_items += n;
        end

        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl
rtl/mf3_pkg.sv
rtl/mf3_stream_if.sv
rtl/mf3_ram.sv
rtl/mf3_core.sv
rtl/median_3x3_rgb_filter_top.sv
rtl/mf3_checker.sv
tb/median_3x3_rgb_filter_top_tb.sv
